// File: rtl/atci_pkg.sv
`default_nettype none

package atci_pkg;

    // stream widths
    localparam int IN_TDATA_W  = 64;   // sector_address + sector_count
    localparam int OUT_TDATA_W = 16;   // reg_offset + reg_value, padded to bytes
    localparam int KIND_W      = 2;
    localparam int ACT_W       = 2;
    localparam int LBA_W       = 48;
    localparam int CNT_W       = 16;
    localparam int OFF_W       = 3;
    localparam int VAL_W       = 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OFF_W - VAL_W;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // sequencer step counter, longest sequence is fourteen actions
    localparam int STEP_W      = 4;

    // configuration register indexes
    localparam logic CFG_USE_LBA48    = 1'b0;
    localparam logic CFG_SELECT_SLAVE = 1'b1;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_READ     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IDENTIFY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

    // actions
    localparam logic [ACT_W-1:0] ACT_WRITE      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WAIT_READY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_WAIT_DRQ   = 2'd2;

    // task-file register offsets
    localparam logic [OFF_W-1:0] OFF_FEATURE = 3'd1;
    localparam logic [OFF_W-1:0] OFF_COUNT   = 3'd2;
    localparam logic [OFF_W-1:0] OFF_LBA_LO  = 3'd3;
    localparam logic [OFF_W-1:0] OFF_LBA_MID = 3'd4;
    localparam logic [OFF_W-1:0] OFF_LBA_HI  = 3'd5;
    localparam logic [OFF_W-1:0] OFF_DEVICE  = 3'd6;
    localparam logic [OFF_W-1:0] OFF_CMD     = 3'd7;
    localparam logic [OFF_W-1:0] OFF_STATUS  = 3'd7;

    // device and status bytes
    localparam logic [VAL_W-1:0] DEV_BASE   = 8'hA0;
    localparam logic [VAL_W-1:0] DEV_LBA    = 8'h40;
    localparam logic [VAL_W-1:0] DEV_SLAVE  = 8'h10;
    localparam logic [VAL_W-1:0] STAT_READY = 8'h40;
    localparam logic [VAL_W-1:0] STAT_DRQ   = 8'h08;
    localparam logic [VAL_W-1:0] FEAT_NONE  = 8'h00;

    // command bytes
    localparam logic [VAL_W-1:0] CMD_READ28   = 8'h20;
    localparam logic [VAL_W-1:0] CMD_WRITE28  = 8'h30;
    localparam logic [VAL_W-1:0] CMD_READ48   = 8'h24;
    localparam logic [VAL_W-1:0] CMD_WRITE48  = 8'h34;
    localparam logic [VAL_W-1:0] CMD_IDENTIFY = 8'hEC;

    typedef enum logic [2:0] {
        SEQ_RD28,
        SEQ_WR28,
        SEQ_RD48,
        SEQ_WR48,
        SEQ_IDENT
    } t_seq;

    typedef struct packed {
        t_seq             seq;
        logic             slave;
        logic [LBA_W-1:0] lba;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [OFF_W-1:0] offset;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_item;

    function automatic t_item wr(input logic [OFF_W-1:0] off, input logic [VAL_W-1:0] val);
        t_item it;
        it.action = ACT_WRITE;
        it.offset = off;
        it.value  = val;
        it.last   = 1'b0;
        return it;
    endfunction

    // one action of a classified request at a given step
    function automatic t_item step_item(input t_entry e, input logic [STEP_W-1:0] step);
        t_item            it;
        logic [VAL_W-1:0] dev;
        t_item            wait_rdy;
        t_item            wait_drq;
        dev = DEV_BASE | DEV_LBA | (e.slave ? DEV_SLAVE : 8'h00);
        wait_rdy = '{action: ACT_WAIT_READY, offset: OFF_STATUS, value: STAT_READY, last: 1'b0};
        wait_drq = '{action: ACT_WAIT_DRQ, offset: OFF_STATUS, value: STAT_DRQ, last: 1'b1};
        it = wr(OFF_DEVICE, dev);
        case (e.seq)
            SEQ_IDENT: begin
                case (step)
                    4'd1:    it = wr(OFF_FEATURE, FEAT_NONE);
                    4'd2:    it = wr(OFF_COUNT, e.cnt[7:0]);
                    4'd3:    it = wr(OFF_LBA_LO, e.lba[7:0]);
                    4'd4:    it = wr(OFF_LBA_MID, e.lba[15:8]);
                    4'd5:    it = wr(OFF_LBA_HI, e.lba[23:16]);
                    4'd6:    it = wait_rdy;
                    4'd7: begin
                        it = wr(OFF_CMD, CMD_IDENTIFY);
                        it.last = 1'b1;
                    end
                    default: it = wr(OFF_DEVICE, dev);
                endcase
            end
            SEQ_RD48, SEQ_WR48: begin
                case (step)
                    4'd1:    it = wr(OFF_FEATURE, FEAT_NONE);
                    4'd2:    it = wr(OFF_COUNT, e.cnt[15:8]);
                    4'd3:    it = wr(OFF_LBA_LO, e.lba[31:24]);
                    4'd4:    it = wr(OFF_LBA_MID, e.lba[39:32]);
                    4'd5:    it = wr(OFF_LBA_HI, e.lba[47:40]);
                    4'd6:    it = wr(OFF_FEATURE, FEAT_NONE);
                    4'd7:    it = wr(OFF_COUNT, e.cnt[7:0]);
                    4'd8:    it = wr(OFF_LBA_LO, e.lba[7:0]);
                    4'd9:    it = wr(OFF_LBA_MID, e.lba[15:8]);
                    4'd10:   it = wr(OFF_LBA_HI, e.lba[23:16]);
                    4'd11:   it = wait_rdy;
                    4'd12: begin
                        it = wr(OFF_CMD, (e.seq == SEQ_WR48) ? CMD_WRITE48 : CMD_READ48);
                        it.last = (e.seq == SEQ_RD48);
                    end
                    4'd13:   it = wait_drq;
                    default: it = wr(OFF_DEVICE, dev);
                endcase
            end
            default: begin
                // 28-bit read and write
                case (step)
                    4'd1:    it = wr(OFF_COUNT, e.cnt[7:0]);
                    4'd2:    it = wr(OFF_LBA_LO, e.lba[7:0]);
                    4'd3:    it = wr(OFF_LBA_MID, e.lba[15:8]);
                    4'd4:    it = wr(OFF_LBA_HI, e.lba[23:16]);
                    4'd5:    it = wr(OFF_DEVICE, dev | {4'h0, e.lba[27:24]});
                    4'd6:    it = wait_rdy;
                    4'd7: begin
                        it = wr(OFF_CMD, (e.seq == SEQ_WR28) ? CMD_WRITE28 : CMD_READ28);
                        it.last = (e.seq == SEQ_RD28);
                    end
                    4'd8:    it = wait_drq;
                    default: it = wr(OFF_DEVICE, dev);
                endcase
            end
        endcase
        return it;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ata_taskfile_command_issuer_core.sv
`default_nettype none

// ATA task-file command issuer. Each request (read, write or identify, with
// a 48-bit sector address and a 16-bit sector count) expands into the ordered
// task-file actions that set up a PIO command: register writes (offset and
// byte), a wait for READY before the command byte and, for writes, a final
// wait for DRQ to send the sector. Action counts per request: 28-bit read 8,
// 28-bit write 9, 48-bit read 13, 48-bit write 14, identify 8. The result
// channel carries one action per cycle while the receiver does not stall,
// and the step counter of the back sequencer walks through each request. The
// front side classifies a request in the cycle it is taken and places it in
// a two-entry request queue, so further requests are taken while earlier ones
// are still being played out, and the output register lets a new action be
// loaded in the same cycle the previous one is taken. A request of kind 3 is
// taken and dropped without any result. Configuration (48-bit mode, second
// drive select) is sampled when a request is taken; the config port is
// always ready.
module ata_taskfile_command_issuer_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write: index 0 use_lba48, index 1 select_slave
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic                            i_cfg_index,
    input  wire logic                            i_cfg_data,
    // request side
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [47:0] sector_address, [63:48] sector_count
    input  wire logic [atci_pkg::IN_TDATA_W-1:0] i_s_tdata,
    // [1:0] kind
    input  wire logic [atci_pkg::KIND_W-1:0]     i_s_tuser,
    // action side
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [2:0] reg_offset, [10:3] reg_value, [15:11] zero
    output logic [atci_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // [1:0] action
    output logic [atci_pkg::ACT_W-1:0]           o_m_tuser,
    // final action of the request
    output logic                                 o_m_tlast
);
    import atci_pkg::*;

    logic   q_full;
    logic   push;
    logic   pop;
    t_entry entry;
    t_head  head;

    // front: config registers, classification of each request
    atci_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_entry     (entry)
    );

    // short queue decoupling front from sequencer
    atci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    // back: step sequencer and output register
    atci_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/atci_front.sv
`default_nettype none

module atci_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic                           i_cfg_index,
    input  wire logic                           i_cfg_data,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [atci_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  wire logic [atci_pkg::KIND_W-1:0]    i_s_tuser,
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output atci_pkg::t_entry                    o_entry
);
    import atci_pkg::*;

    logic r_use_lba48;
    logic r_select_slave;
    logic keep;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_lba48    <= 1'b0;
            r_select_slave <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_USE_LBA48:    r_use_lba48    <= i_cfg_data;
                CFG_SELECT_SLAVE: r_select_slave <= i_cfg_data;
                default:          r_use_lba48    <= r_use_lba48;
            endcase
        end
    end

    // classify the request into one of the action sequences
    always_comb begin
        keep = 1'b1;
        o_entry.seq = SEQ_IDENT;
        unique case (i_s_tuser)
            KIND_READ:     o_entry.seq = r_use_lba48 ? SEQ_RD48 : SEQ_RD28;
            KIND_WRITE:    o_entry.seq = r_use_lba48 ? SEQ_WR48 : SEQ_WR28;
            KIND_IDENTIFY: o_entry.seq = SEQ_IDENT;
            KIND_NONE:     keep = 1'b0;
            default:       keep = 1'b0;
        endcase
        o_entry.slave = r_select_slave;
        o_entry.lba   = i_s_tdata[LBA_W-1:0];
        o_entry.cnt   = i_s_tdata[LBA_W +: CNT_W];
    end

    // undefined kind is taken and dropped
    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full && keep;

endmodule

`default_nettype wire

// File: rtl/atci_queue.sv
`default_nettype none

module atci_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire atci_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output logic                  o_full,
    output atci_pkg::t_head       o_head
);
    import atci_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/atci_back.sv
`default_nettype none

module atci_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire atci_pkg::t_head                  i_head,
    output logic                                  o_pop,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [atci_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    output logic [atci_pkg::ACT_W-1:0]            o_m_tuser,
    output logic                                  o_m_tlast
);
    import atci_pkg::*;

    logic              r_valid;
    t_item             r_item;
    logic [STEP_W-1:0] r_step;
    t_item             cur;
    logic              load;

    always_comb begin
        cur   = step_item(i_head.entry, r_step);
        load  = i_head.valid && (!r_valid || i_m_tready);
        o_pop = load && cur.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= cur.last ? '0 : r_step + 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= cur;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_item.action;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_item.value, r_item.offset};
    assign o_m_tlast  = r_item.last;

endmodule

`default_nettype wire

// File: rtl/atci_checker.sv
`default_nettype none

module atci_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [atci_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic [atci_pkg::ACT_W-1:0]      o_m_tuser,
    input wire logic                            o_m_tlast
);
    import atci_pkg::*;

    // stalled action holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled action changed");

    // nothing pending right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("action valid after reset");

    // drq wait always closes a request
    a_drq_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ACT_WAIT_DRQ |-> o_m_tlast)
        else $error("drq wait not last");

    // ready wait polls status with the ready mask
    a_rdy_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ACT_WAIT_READY |->
            o_m_tdata[OFF_W-1:0] == OFF_STATUS
            && o_m_tdata[OFF_W +: VAL_W] == STAT_READY && !o_m_tlast)
        else $error("bad ready wait");

    // command byte follows the ready wait at once
    a_cmd_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tuser == ACT_WAIT_READY |=>
            o_m_tvalid && o_m_tuser == ACT_WRITE && o_m_tdata[OFF_W-1:0] == OFF_CMD)
        else $error("command byte missing after ready wait");

endmodule

bind ata_taskfile_command_issuer_core atci_checker u_atci_checker (.*);

`default_nettype wire

// File: tb/tb_ata_taskfile_command_issuer_core.sv
module tb_ata_taskfile_command_issuer_core;

    import atci_pkg::*;

    localparam int STALL_LIMIT = 3000;  // cycles with no handshake anywhere
    localparam int LONG_HOLD   = 300;   // receiver hold-off for the pressure phase
    localparam int QUIET_WAIT  = 40;    // lets a dropped request clear the pipe

    // one disk request as the sender holds it
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [LBA_W-1:0]  lba;
        logic [CNT_W-1:0]  cnt;
    } t_disk_req;

    // one task-file action as the block should emit it
    typedef struct {
        logic [ACT_W-1:0] act;
        logic [OFF_W-1:0] off;
        logic [VAL_W-1:0] val;
        logic             last;
    } t_tf_action;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   i_cfg_index = 1'b0;
    logic                   i_cfg_data  = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic [KIND_W-1:0]      i_s_tuser   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [ACT_W-1:0]       o_m_tuser;
    logic                   o_m_tlast;

    // local copy of the two configuration bits
    logic lba48_mode = 1'b0;
    logic slave_sel  = 1'b0;

    t_disk_req  queued_reqs[$];   // requests not yet offered
    t_tf_action due_actions[$];   // actions still owed by the block

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_arm       = 0;       // bumped by the stimulus to ask for a long hold-off
    int hold_seen      = 0;
    int hold_left      = 0;
    int fault_cnt      = 0;
    int quiet_cycles   = 0;

    ata_taskfile_command_issuer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // action predictor
    // ------------------------------------------------------------------

    function automatic void post(input logic [ACT_W-1:0] act, input logic [OFF_W-1:0] off,
                                 input logic [VAL_W-1:0] val, input logic last);
        t_tf_action a;
        a.act  = act;
        a.off  = off;
        a.val  = val;
        a.last = last;
        due_actions.push_back(a);
    endfunction

    // queues the task-file actions one request should produce
    function automatic void expand_request(input logic [KIND_W-1:0] kind,
                                           input logic [LBA_W-1:0] lba,
                                           input logic [CNT_W-1:0] cnt);
        logic [VAL_W-1:0] dev;
        logic [VAL_W-1:0] cmd;
        dev = DEV_BASE | DEV_LBA | (slave_sel ? DEV_SLAVE : 8'h00);
        // unknown kind: taken and dropped, nothing owed
        if (kind == KIND_NONE)
            return;
        post(ACT_WRITE, OFF_DEVICE, dev, 1'b0);
        if (kind == KIND_IDENTIFY) begin
            // identify ignores the addressing mode and the count high byte
            post(ACT_WRITE, OFF_FEATURE, FEAT_NONE, 1'b0);
            post(ACT_WRITE, OFF_COUNT,   cnt[7:0],   1'b0);
            post(ACT_WRITE, OFF_LBA_LO,  lba[7:0],   1'b0);
            post(ACT_WRITE, OFF_LBA_MID, lba[15:8],  1'b0);
            post(ACT_WRITE, OFF_LBA_HI,  lba[23:16], 1'b0);
            cmd = CMD_IDENTIFY;
        end else if (lba48_mode) begin
            // high-order bytes go in first, then the low-order ones
            post(ACT_WRITE, OFF_FEATURE, FEAT_NONE,  1'b0);
            post(ACT_WRITE, OFF_COUNT,   cnt[15:8],  1'b0);
            post(ACT_WRITE, OFF_LBA_LO,  lba[31:24], 1'b0);
            post(ACT_WRITE, OFF_LBA_MID, lba[39:32], 1'b0);
            post(ACT_WRITE, OFF_LBA_HI,  lba[47:40], 1'b0);
            post(ACT_WRITE, OFF_FEATURE, FEAT_NONE,  1'b0);
            post(ACT_WRITE, OFF_COUNT,   cnt[7:0],   1'b0);
            post(ACT_WRITE, OFF_LBA_LO,  lba[7:0],   1'b0);
            post(ACT_WRITE, OFF_LBA_MID, lba[15:8],  1'b0);
            post(ACT_WRITE, OFF_LBA_HI,  lba[23:16], 1'b0);
            cmd = (kind == KIND_WRITE) ? CMD_WRITE48 : CMD_READ48;
        end else begin
            // 28-bit: address bits 27..24 ride in the device byte, 47..28 are lost
            post(ACT_WRITE, OFF_COUNT,   cnt[7:0],   1'b0);
            post(ACT_WRITE, OFF_LBA_LO,  lba[7:0],   1'b0);
            post(ACT_WRITE, OFF_LBA_MID, lba[15:8],  1'b0);
            post(ACT_WRITE, OFF_LBA_HI,  lba[23:16], 1'b0);
            post(ACT_WRITE, OFF_DEVICE,  dev | {4'h0, lba[27:24]}, 1'b0);
            cmd = (kind == KIND_WRITE) ? CMD_WRITE28 : CMD_READ28;
        end
        post(ACT_WAIT_READY, OFF_STATUS, STAT_READY, 1'b0);
        post(ACT_WRITE, OFF_CMD, cmd, kind != KIND_WRITE);
        if (kind == KIND_WRITE)
            post(ACT_WAIT_DRQ, OFF_STATUS, STAT_DRQ, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // request driver: offers queued requests, predicts on each handshake
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : req_driver
        t_disk_req nxt;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                expand_request(i_s_tuser, i_s_tdata[LBA_W-1:0],
                               i_s_tdata[IN_TDATA_W-1:LBA_W]);
            // a request still waiting for tready is held as it is
            if (!i_s_tvalid || o_s_tready) begin
                if (queued_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = queued_reqs.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= nxt.kind;
                    i_s_tdata  <= {nxt.cnt, nxt.lba};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // action receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_arm != hold_seen) begin
                hold_seen = hold_arm;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left  = hold_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // action monitor: compares each taken action with the oldest one owed
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : action_monitor
        t_tf_action want;
        logic [OFF_W-1:0] got_off;
        logic [VAL_W-1:0] got_val;
        logic [OUT_TDATA_W-OFF_W-VAL_W-1:0] got_pad;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_off = o_m_tdata[OFF_W-1:0];
            got_val = o_m_tdata[OFF_W+VAL_W-1:OFF_W];
            got_pad = o_m_tdata[OUT_TDATA_W-1:OFF_W+VAL_W];
            if (due_actions.size() == 0) begin
                if (fault_cnt < 10)
                    $display("unexpected action: act %0d off %0d val %02h last %0b",
                             o_m_tuser, got_off, got_val, o_m_tlast);
                fault_cnt++;
            end else begin
                want = due_actions.pop_front();
                if (o_m_tuser !== want.act || got_off !== want.off ||
                    got_val !== want.val || o_m_tlast !== want.last || got_pad !== '0) begin
                    if (fault_cnt < 10) begin
                        $write("action mismatch: expected act %0d off %0d val %02h last %0b",
                               want.act, want.off, want.val, want.last);
                        $display(" / got act %0d off %0d val %02h last %0b pad %h",
                                 o_m_tuser, got_off, got_val, o_m_tlast, got_pad);
                    end
                    fault_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run when no handshake happens for too long
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** ata_taskfile_command_issuer_core: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    function automatic void add_req(input logic [KIND_W-1:0] kind,
                                    input logic [LBA_W-1:0] lba,
                                    input logic [CNT_W-1:0] cnt);
        t_disk_req r;
        r.kind = kind;
        r.lba  = lba;
        r.cnt  = cnt;
        queued_reqs.push_back(r);
    endfunction

    // config register write, only issued while the block is idle
    task automatic write_reg(input logic idx, input logic val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_USE_LBA48)
            lba48_mode = val;
        else
            slave_sel = val;
    endtask

    task automatic set_mode(input logic lba48, input logic slave);
        write_reg(CFG_USE_LBA48, lba48);
        write_reg(CFG_SELECT_SLAVE, slave);
    endtask

    // sender pauses until every owed action has come, then a quiet gap
    // so that a dropped request has left the block as well
    task automatic drain;
        while (queued_reqs.size() != 0 || i_s_tvalid || due_actions.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_WAIT) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int               n;
        logic [KIND_W-1:0] kind;
        logic [LBA_W-1:0]  lba;
        int               shape;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // directed: reset mode is 28-bit, first drive
        add_req(KIND_READ,     48'h0,              16'h0);
        add_req(KIND_WRITE,    48'hFFFF_FFFF_FFFF, 16'hFFFF);
        add_req(KIND_IDENTIFY, 48'h5A5A_5A12_3456, 16'hA5C3);
        add_req(KIND_NONE,     48'hFFFF_FFFF_FFFF, 16'hFFFF);
        add_req(KIND_READ,     48'hFFFF_F000_0000, 16'h00FF);   // only ignored address bits set
        add_req(KIND_WRITE,    48'h0000_0ABC_DEF1, 16'hFF00);
        drain();

        set_mode(1'b1, 1'b1);
        add_req(KIND_READ,     48'h0,              16'h0);
        add_req(KIND_WRITE,    48'hFFFF_FFFF_FFFF, 16'hFFFF);
        add_req(KIND_IDENTIFY, 48'hFFFF_FFFF_FFFF, 16'h1234);
        add_req(KIND_WRITE,    48'h8000_0000_0001, 16'h8001);
        add_req(KIND_NONE,     48'h0,              16'h0);
        drain();

        set_mode(1'b0, 1'b1);
        add_req(KIND_READ,     48'hFFFF_FFFF_FFFF, 16'hFFFF);
        add_req(KIND_WRITE,    48'h0000_0A5C_3E7F, 16'h0042);
        add_req(KIND_IDENTIFY, 48'h0,              16'h0);
        drain();

        set_mode(1'b1, 1'b0);
        add_req(KIND_READ,     48'h0123_4567_89AB, 16'hFEDC);
        add_req(KIND_WRITE,    48'h0,              16'h0);
        add_req(KIND_IDENTIFY, 48'hFEDC_BA98_7654, 16'hFFFF);
        drain();

        // random phases, each under its own mode and idling pattern
        for (int p = 0; p < 6; p++) begin
            set_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 61;
                end
                default: begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            // pressure: sender keeps offering while the receiver holds off,
            // so the request queue fills and tready drops
            if (p == 4)
                hold_arm = hold_arm + 1;
            n = 0;
            while (n < 16) begin
                if ($urandom_range(99) < 8)
                    kind = KIND_NONE;
                else
                    kind = KIND_W'($urandom_range(2));
                shape = $urandom_range(9);
                if (shape == 0)
                    lba = '0;
                else if (shape == 1)
                    lba = '1;
                else
                    lba = LBA_W'({$urandom, $urandom});
                add_req(kind, lba, CNT_W'($urandom));
                if (kind != KIND_NONE)
                    n++;
            end
            drain();
        end

        if (fault_cnt == 0 && due_actions.size() == 0) begin
            $display("** ata_taskfile_command_issuer_core: PASSED **");
        end else begin
            $display("** ata_taskfile_command_issuer_core: FAILED **");
        end
        $finish;
    end

endmodule
